// File: hw/rtl/u8san_pkg.sv
// ----------------------------------------------------------------------------
// u8san_pkg
// Shared types and byte-class constants for the UTF-8 sequence sanitizer.
// ----------------------------------------------------------------------------
package u8san_pkg;

   // Byte class masks and codes
   localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
   localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
   localparam logic [7:0] CONT_CODE  = 8'b1000_0000;
   localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
   localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
   localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
   localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
   localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
   localparam logic [7:0] LEAD4_CODE = 8'b1111_0000;

   // Sequence lengths
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_2    = 3'd2;
   localparam logic [2:0] LEN_3    = 3'd3;
   localparam logic [2:0] LEN_4    = 3'd4;

   localparam int HELD_DEPTH = 3;
   localparam int JOB_BYTES  = 4;

   // One job: the result beats caused by one accepted input beat
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [1:0]                last_idx;
      logic                      has_byte;
      logic                      eos;
   } job_type;

   // Front to queue write port
   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // Queue to back read port
   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// File: hw/rtl/u8san_front.sv
// ----------------------------------------------------------------------------
// u8san_front
// Accepts one byte per beat, classifies it, tracks the pending multibyte
// sequence and emits a job whenever the beat produces results.
// ----------------------------------------------------------------------------
module u8san_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_string,
   input  logic               q_full,
   output u8san_pkg::push_type push
);
   import u8san_pkg::*;

   logic [HELD_DEPTH-1:0][7:0] held_ff, held_in;
   logic [2:0]                 exp_len_ff, exp_len_in;
   logic [1:0]                 held_cnt_ff, held_cnt_in;
   logic                       accept;
   logic                       emit;
   logic [1:0]                 last_idx;
   logic                       has_byte;
   logic [JOB_BYTES-1:0][7:0]  em;
   logic [2:0]                 lead_len;
   logic [7:0]                 b;

   assign b         = req_in_byte;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Decode lead byte length
   always_comb begin
      priority if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         lead_len = LEN_2;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         lead_len = LEN_3;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         lead_len = LEN_4;
      end else begin
         lead_len = LEN_NONE;
      end
   end

   // Classify the byte and compute next sequence state and job
   always_comb begin
      held_in     = held_ff;
      exp_len_in  = exp_len_ff;
      held_cnt_in = held_cnt_ff;
      emit        = 1'b0;
      last_idx    = 2'd0;
      has_byte    = 1'b1;
      for (int k = 0; k < HELD_DEPTH; k++) begin
         em[k] = held_ff[k];
      end
      em[JOB_BYTES-1] = 8'd0;

      priority if ((b & ASCII_MASK) == 8'd0) begin
         // ASCII: drop pending, pass byte
         exp_len_in  = LEN_NONE;
         held_cnt_in = 2'd0;
         em[0]       = b;
         emit        = 1'b1;
      end else if ((b & CONT_MASK) == CONT_CODE) begin
         if (exp_len_ff != LEN_NONE) begin
            if ({1'b0, held_cnt_ff} + 3'd1 == exp_len_ff) begin
               // Sequence complete: emit held bytes plus this one
               em[held_cnt_ff] = b;
               last_idx        = held_cnt_ff;
               emit            = 1'b1;
               exp_len_in      = LEN_NONE;
               held_cnt_in     = 2'd0;
            end else if (held_cnt_ff < 2'd3) begin
               held_in[held_cnt_ff] = b;
               held_cnt_in          = held_cnt_ff + 2'd1;
            end else begin
               exp_len_in  = LEN_NONE;
               held_cnt_in = 2'd0;
            end
         end
      end else begin
         // Lead or invalid byte: restart
         exp_len_in  = LEN_NONE;
         held_cnt_in = 2'd0;
         if (lead_len != LEN_NONE) begin
            held_in[0]  = b;
            held_cnt_in = 2'd1;
            exp_len_in  = lead_len;
         end
      end

      // End of string: drop pending, give a bare marker if nothing passed
      if (req_end_of_string) begin
         exp_len_in  = LEN_NONE;
         held_cnt_in = 2'd0;
         if (!emit) begin
            em[0]    = 8'd0;
            has_byte = 1'b0;
            emit     = 1'b1;
            last_idx = 2'd0;
         end
      end
   end

   assign push.valid        = accept && emit;
   assign push.job.bytes    = em;
   assign push.job.last_idx = last_idx;
   assign push.job.has_byte = has_byte;
   assign push.job.eos      = req_end_of_string;

   // Advance sequence state on accepted beats
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= LEN_NONE;
         held_cnt_ff <= 2'd0;
      end else if (accept) begin
         exp_len_ff  <= exp_len_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   // Hold sequence bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// File: hw/rtl/u8san_queue.sv
// ----------------------------------------------------------------------------
// u8san_queue
// Short job queue between the classifier front and the serializing back.
// ----------------------------------------------------------------------------
module u8san_queue #(
   parameter int Depth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  u8san_pkg::push_type push,
   output logic                full,
   output u8san_pkg::head_type head,
   input  logic                pop
);
   import u8san_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   job_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (cnt_ff == FullCnt);
   assign head.valid = (cnt_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the job slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: hw/rtl/u8san_back.sv
// ----------------------------------------------------------------------------
// u8san_back
// Walks the head job one byte per beat into the result output register.
// ----------------------------------------------------------------------------
module u8san_back (
   input  logic                clock,
   input  logic                reset,
   input  u8san_pkg::head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic                rsp_run_last,
   output logic                rsp_string_end
);
   import u8san_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       has_ff;
   logic       run_last_ff;
   logic       str_end_ff;
   logic       load;
   logic       at_last;

   assign load    = head.valid && (!valid_ff || !rsp_stall);
   assign at_last = (idx_ff == head.job.last_idx);
   assign pop     = load && at_last;

   // Step through the job and refill the output register
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= head.job.bytes[idx_ff];
         has_ff      <= head.job.has_byte;
         run_last_ff <= at_last;
         str_end_ff  <= at_last && head.job.eos;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = str_end_ff;

endmodule

// File: hw/rtl/utf8_sequence_sanitizer_core.sv
// ----------------------------------------------------------------------------
// utf8_sequence_sanitizer_core
// Filters a byte stream down to structurally complete UTF-8 sequences.
// Usage:
//   Input beats (req_*) carry one raw byte and an end-of-string flag. Each
//   result beat (rsp_*) carries one passed byte; rsp_run_last marks the last
//   beat caused by an input byte, rsp_string_end the final beat of a string.
//   A string end that passes no byte gives one bare marker beat with
//   rsp_has_byte low and rsp_out_byte zero.
//   ASCII bytes pass alone; a 2, 3 or 4 byte sequence is released as a burst
//   of beats when its last continuation byte arrives.
// Timing:
//   One input beat per cycle is taken while req_stall is low. A result is
//   held in the job queue, then in the single output register of the back end;
//   a burst leaves there at one beat per cycle while rsp_stall is low. At most
//   four beats wait behind the output, so the default five-entry job queue
//   fills only while rsp_stall is high; the front stalls only when it is full.
// Reset: synchronous reset clears the pending sequence, the queue and rsp_valid.
// Stall: while rsp_stall is high the output beat holds; jobs collect in the
//   queue and req_stall rises once it fills.
// ----------------------------------------------------------------------------
module utf8_sequence_sanitizer_core #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import u8san_pkg::*;

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   // Classify input bytes
   u8san_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_full            (q_full),
      .push              (push)
   );

   // Decouple front and back
   u8san_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // Serialize jobs into result beats
   u8san_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule
